### rtl/vpfc_pkg.sv
// Shared types, constants and helper functions for the video pixel format converter.
// Used by vpfc_core, video_pixel_format_converter_top and the testbench; depends on nothing else.
package vpfc_pkg;

    // Configuration register indexes.
    localparam logic CFG_SOURCE_FORMAT = 1'b0;
    localparam logic CFG_OUTPUT_DEPTH  = 1'b1;

    // Source format codes.
    localparam logic [1:0] SRC_PLANAR_420 = 2'd0;
    localparam logic [1:0] SRC_PACKED_422 = 2'd1;
    localparam logic [1:0] SRC_RGB32      = 2'd2;

    // Output depth codes.
    localparam logic [1:0] DEPTH_RGB555 = 2'd0;
    localparam logic [1:0] DEPTH_RGB565 = 2'd1;
    localparam logic [1:0] DEPTH_BGR24  = 2'd2;
    localparam logic [1:0] DEPTH_BGR32  = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [1:0] SOURCE_FORMAT_RESET = SRC_PLANAR_420;
    localparam logic [1:0] OUTPUT_DEPTH_RESET  = DEPTH_RGB565;

    // Signed accumulator wide enough for every product and sum in both YUV paths.
    typedef logic signed [27:0] t_acc;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [1:0] source_format;
        logic [1:0] output_depth;
    } t_cfg;

    // Planar 4:2:0 coefficients in 16.16 fixed point.
    localparam t_acc C_Y_SCALE = 28'sd76283;
    localparam t_acc C_CB_TO_B = 28'sd132186;
    localparam t_acc C_CB_TO_G = 28'sd25690;
    localparam t_acc C_CR_TO_G = 28'sd53280;
    localparam t_acc C_CR_TO_R = 28'sd104595;

    // Packed 4:2:2 coefficients in 8.8 fixed point.
    localparam t_acc C_P_CB_TO_B = 28'sd454;
    localparam t_acc C_P_CB_TO_G = 28'sd88;
    localparam t_acc C_P_CR_TO_G = 28'sd183;
    localparam t_acc C_P_CR_TO_R = 28'sd359;

    // Clamp limits.
    localparam t_acc LIM16_HI = 28'sh0FFFFFF;
    localparam t_acc LIM16_LO = 28'sh000FFFF;
    localparam t_acc LIM8_HI  = 28'sh000FFFF;
    localparam t_acc LIM8_LO  = 28'sh00000FF;

    // Clamp a 16.16 sum to a byte.
    function automatic logic [7:0] clip16(input t_acc x);
        logic [7:0] res;
        if (x > LIM16_HI) begin
            res = 8'hFF;
        end else if (x <= LIM16_LO) begin
            res = 8'h00;
        end else begin
            res = x[23:16];
        end
        return res;
    endfunction

    // Clamp an 8.8 sum to a byte.
    function automatic logic [7:0] clip8(input t_acc x);
        logic [7:0] res;
        if (x > LIM8_HI) begin
            res = 8'hFF;
        end else if (x <= LIM8_LO) begin
            res = 8'h00;
        end else begin
            res = x[15:8];
        end
        return res;
    endfunction

    // Pack three bytes into the selected output depth; low bits are truncated for RGB555 and RGB565.
    function automatic logic [23:0] pack(input logic [1:0] depth, input logic [7:0] r,
                                         input logic [7:0] g, input logic [7:0] b);
        logic [23:0] res;
        case (depth)
            DEPTH_RGB555: res = {9'd0, r[7:3], g[7:3], b[7:3]};
            DEPTH_RGB565: res = {8'd0, r[7:3], g[7:2], b[7:3]};
            default:      res = {r, g, b};
        endcase
        return res;
    endfunction

endpackage

### rtl/vpfc_core.sv
// Two-stage conversion datapath: coefficient products, then sums, clamp and pack.
// Depends on vpfc_pkg for coefficients, the config struct and the clamp/pack functions.
module vpfc_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  vpfc_pkg::t_cfg     i_cfg,
    input  logic [7:0]         i_luma,
    input  logic [7:0]         i_chroma_u,
    input  logic [7:0]         i_chroma_v,
    input  logic [23:0]        i_rgb_word,
    output logic [23:0]        o_pixel,
    output logic               o_strobe
);
    import vpfc_pkg::*;

    logic signed [9:0] ys;
    logic signed [9:0] us;
    logic signed [9:0] vs;

    t_acc n_y_term, n_r_term, n_gu_term, n_gv_term, n_b_term;
    t_acc r_y_term, r_r_term, r_gu_term, r_gv_term, r_b_term;
    logic [23:0] r_rgb;
    t_cfg        r_cfg;
    logic        r_prod_valid;

    t_acc        sum_r, sum_g, sum_b;
    logic [7:0]  red, green, blue;
    logic [23:0] n_pixel;
    logic [23:0] r_pixel;
    logic        r_strobe;

    // Offset the samples: luma minus 16 and chroma minus 128.
    assign ys = $signed({2'b00, i_luma}) - 10'sd16;
    assign us = $signed({2'b00, i_chroma_u}) - 10'sd128;
    assign vs = $signed({2'b00, i_chroma_v}) - 10'sd128;

    // Coefficient products for the selected YUV scheme.
    always_comb begin
        if (i_cfg.source_format == SRC_PLANAR_420) begin
            n_y_term  = t_acc'(ys) * C_Y_SCALE;
            n_r_term  = t_acc'(vs) * C_CR_TO_R;
            n_gu_term = t_acc'(us) * C_CB_TO_G;
            n_gv_term = t_acc'(vs) * C_CR_TO_G;
            n_b_term  = t_acc'(us) * C_CB_TO_B;
        end else begin
            n_y_term  = {12'd0, i_luma, 8'd0};
            n_r_term  = t_acc'(vs) * C_P_CR_TO_R;
            n_gu_term = t_acc'(us) * C_P_CB_TO_G;
            n_gv_term = t_acc'(vs) * C_P_CR_TO_G;
            n_b_term  = t_acc'(us) * C_P_CB_TO_B;
        end
    end

    // Product stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else begin
            r_prod_valid <= i_valid;
        end
        r_y_term  <= n_y_term;
        r_r_term  <= n_r_term;
        r_gu_term <= n_gu_term;
        r_gv_term <= n_gv_term;
        r_b_term  <= n_b_term;
        r_rgb     <= i_rgb_word;
        r_cfg     <= i_cfg;
    end

    // Sums for the three channels.
    assign sum_r = r_y_term + r_r_term;
    assign sum_g = r_y_term - r_gu_term - r_gv_term;
    assign sum_b = r_y_term + r_b_term;

    // Clamp or split by source format, then pack to the output depth; an unknown source gives zero.
    always_comb begin
        red   = r_rgb[23:16];
        green = r_rgb[15:8];
        blue  = r_rgb[7:0];
        case (r_cfg.source_format)
            SRC_PLANAR_420: begin
                red   = clip16(sum_r);
                green = clip16(sum_g);
                blue  = clip16(sum_b);
            end
            SRC_PACKED_422: begin
                red   = clip8(sum_r);
                green = clip8(sum_g);
                blue  = clip8(sum_b);
            end
            default: begin
                red   = r_rgb[23:16];
                green = r_rgb[15:8];
                blue  = r_rgb[7:0];
            end
        endcase
        if (r_cfg.source_format == SRC_RGB32 || r_cfg.source_format == SRC_PLANAR_420 ||
            r_cfg.source_format == SRC_PACKED_422) begin
            n_pixel = pack(r_cfg.output_depth, red, green, blue);
        end else begin
            n_pixel = 24'd0;
        end
    end

    // Result register and strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_prod_valid;
        end
        r_pixel <= n_pixel;
    end

    assign o_pixel  = r_pixel;
    assign o_strobe = r_strobe;

endmodule

### rtl/video_pixel_format_converter_top.sv
// Top level of the video pixel format converter: config registers, input register, datapath.
// Depends on vpfc_pkg and vpfc_core.
//
// Usage:
//   Input channel: a pixel transfer happens at a rising edge with start high and busy
//   low. busy is never raised, so one pixel may be transferred in every cycle.
//   The pixel is luma plus its chroma pair (YUV sources) or a 24-bit RGB word.
//   Output channel: each pixel yields exactly one result on o_pixel, marked by o_strobe
//   for one cycle. The receiver cannot stall; results must be taken when shown.
//   Pipeline: the transfer edge loads the input register; the pixel then passes through
//   the product register and the result register, where o_pixel and o_strobe show it.
//   Throughput: one pixel per cycle, set by the single pass through the two arithmetic
//   stages; the constant-coefficient multiplies sit in the product stage.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index at once (0 source
//   format, 1 output depth). Writes must be made only while no pixel is in flight; the block
//   does not enforce this. Reset (synchronous, active low) clears all strobes and restores
//   source format planar 4:2:0 and output depth RGB565; in-flight pixels are dropped.
module video_pixel_format_converter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_luma,
    input  logic [7:0]  i_chroma_u,
    input  logic [7:0]  i_chroma_v,
    input  logic [23:0] i_rgb_word,
    output logic [23:0] o_pixel,
    output logic        o_strobe,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [1:0]  i_cfg_data
);
    import vpfc_pkg::*;

    logic [1:0]  r_source_format;
    logic [1:0]  r_output_depth;
    t_cfg        cfg;
    logic        r_in_valid;
    logic [7:0]  r_luma;
    logic [7:0]  r_chroma_u;
    logic [7:0]  r_chroma_v;
    logic [23:0] r_rgb_word;

    // The block never holds off a transfer.
    assign busy = 1'b0;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_format <= SOURCE_FORMAT_RESET;
            r_output_depth  <= OUTPUT_DEPTH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SOURCE_FORMAT: r_source_format <= i_cfg_data;
                CFG_OUTPUT_DEPTH:  r_output_depth  <= i_cfg_data;
            endcase
        end
    end

    assign cfg.source_format = r_source_format;
    assign cfg.output_depth  = r_output_depth;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
        r_luma     <= i_luma;
        r_chroma_u <= i_chroma_u;
        r_chroma_v <= i_chroma_v;
        r_rgb_word <= i_rgb_word;
    end

    // Conversion datapath.
    vpfc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_in_valid),
        .i_cfg      (cfg),
        .i_luma     (r_luma),
        .i_chroma_u (r_chroma_u),
        .i_chroma_v (r_chroma_v),
        .i_rgb_word (r_rgb_word),
        .o_pixel    (o_pixel),
        .o_strobe   (o_strobe)
    );

endmodule

### rtl/vpfc_checker.sv
// Port-level checker for the video pixel format converter, bound to the top level.
// Depends only on the ports of video_pixel_format_converter_top.
module vpfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [23:0] o_pixel,
    input logic        o_strobe
);

    // The converter never refuses a transfer.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    // Every transferred pixel produces a result strobe.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##2 o_strobe)
        else $error("result missing after pixel transfer");

    // No result appears without a matching transfer.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 3))
        else $error("result without a pixel transfer");

    // The pipeline is empty right after reset.
    a_clear_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_strobe)
        else $error("strobe set just after reset");

    // A result pixel carries no unknown bits.
    a_pixel_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !$isunknown(o_pixel))
        else $error("result pixel has unknown bits");

endmodule

bind video_pixel_format_converter_top vpfc_checker u_vpfc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_pixel  (o_pixel),
    .o_strobe (o_strobe)
);

### sim/testbench.sv
// Self-checking testbench for video_pixel_format_converter_top: directed pixel table, then
// random pixels, each known source format at every depth and the unknown one at RGB555,
// checked against a local predictor. Depends on vpfc_pkg and the converter RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vpfc_pkg::*;

    // Source format code that the block does not convert.
    localparam logic [1:0] SRC_UNKNOWN = 2'd3;
    // Cycles to wait after the last pending pixel has come out, before a configuration change.
    localparam int PIPE_CYCLES = 4;
    localparam int END_CYCLES  = 8;
    localparam int CYCLE_LIMIT = 50000;
    localparam int RANDOM_PER_PHASE = 54;

    // One row of the directed pixel table.
    typedef struct {
        logic [1:0]  src;
        logic [1:0]  depth;
        logic [7:0]  luma;
        logic [7:0]  cb;
        logic [7:0]  cr;
        logic [23:0] word;
        bit          known;
        logic [23:0] want;
    } t_pixel_row;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic        busy;
    logic [7:0]  i_luma      = 8'd0;
    logic [7:0]  i_chroma_u  = 8'd0;
    logic [7:0]  i_chroma_v  = 8'd0;
    logic [23:0] i_rgb_word  = 24'd0;
    logic [23:0] o_pixel;
    logic        o_strobe;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [1:0]  i_cfg_data  = 2'd0;

    // Local copy of the configuration registers.
    logic [1:0]  src_fmt   = SOURCE_FORMAT_RESET;
    logic [1:0]  out_depth = OUTPUT_DEPTH_RESET;

    logic [23:0] pending_pixels[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    bit          gaps_on        = 1'b1;

    t_pixel_row  pixel_table[$];

    video_pixel_format_converter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_luma      (i_luma),
        .i_chroma_u  (i_chroma_u),
        .i_chroma_v  (i_chroma_v),
        .i_rgb_word  (i_rgb_word),
        .o_pixel     (o_pixel),
        .o_strobe    (o_strobe),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock generator.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Saturate a 16.16 sum to a byte; negative sums give zero.
    function automatic logic [7:0] sat_q16(input int sum);
        logic [7:0] res;
        if (sum > 32'sh00FFFFFF) begin
            res = 8'hFF;
        end else if (sum <= 32'sh0000FFFF) begin
            res = 8'h00;
        end else begin
            res = sum[23:16];
        end
        return res;
    endfunction

    // Saturate an 8.8 sum to a byte; negative sums give zero.
    function automatic logic [7:0] sat_q8(input int sum);
        logic [7:0] res;
        if (sum > 32'sh0000FFFF) begin
            res = 8'hFF;
        end else if (sum <= 32'sh000000FF) begin
            res = 8'h00;
        end else begin
            res = sum[15:8];
        end
        return res;
    endfunction

    // Expected output pixel for one input pixel under the current configuration.
    function automatic logic [23:0] convert_pixel(input logic [7:0] luma, input logic [7:0] cb,
                                                  input logic [7:0] cr, input logic [23:0] word);
        int         y;
        int         u;
        int         v;
        int         yl;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [23:0] px;
        y = luma;
        u = int'(cb) - 128;
        v = int'(cr) - 128;
        case (src_fmt)
            SRC_PLANAR_420: begin
                yl = (y - 16) * 76283;
                r = sat_q16(yl + 104595 * v);
                g = sat_q16(yl - 53280 * v - 25690 * u);
                b = sat_q16(yl + 132186 * u);
            end
            SRC_PACKED_422: begin
                yl = y * 256;
                r = sat_q8(yl + 359 * v);
                g = sat_q8(yl - 88 * u - 183 * v);
                b = sat_q8(yl + 454 * u);
            end
            default: begin
                r = word[23:16];
                g = word[15:8];
                b = word[7:0];
            end
        endcase
        // Reduced depths keep the top bits of each byte.
        case (out_depth)
            DEPTH_RGB555: px = {9'd0, r[7:3], g[7:3], b[7:3]};
            DEPTH_RGB565: px = {8'd0, r[7:3], g[7:2], b[7:3]};
            default:      px = {r, g, b};
        endcase
        if (src_fmt == SRC_UNKNOWN) begin
            px = 24'd0;
        end
        return px;
    endfunction

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Transfer one pixel; entered and left at a falling edge.
    task automatic push_pixel(input logic [7:0] luma, input logic [7:0] cb, input logic [7:0] cr,
                              input logic [23:0] word, input bit known, input logic [23:0] want);
        while (gaps_on && $urandom_range(99) < 36) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start      <= 1'b1;
        i_luma     <= luma;
        i_chroma_u <= cb;
        i_chroma_v <= cr;
        i_rgb_word <= word;
        do @(posedge i_clk); while (busy);
        pending_pixels.push_back(known ? want : convert_pixel(luma, cb, cr, word));
        @(negedge i_clk);
    endtask

    // Let every pixel in flight come out before the configuration changes.
    task automatic drain_pipeline();
        start <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (PIPE_CYCLES) @(negedge i_clk);
    endtask

    // Write both configuration registers; the block must be idle.
    task automatic apply_config(input logic [1:0] src, input logic [1:0] depth);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SOURCE_FORMAT;
        i_cfg_data  <= src;
        @(negedge i_clk);
        i_cfg_index <= CFG_OUTPUT_DEPTH;
        i_cfg_data  <= depth;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        src_fmt   = src;
        out_depth = depth;
    endtask

    // Random byte with the extremes weighted up.
    function automatic logic [7:0] rand_byte();
        logic [7:0] val;
        case ($urandom_range(7))
            0:       val = 8'h00;
            1:       val = 8'hFF;
            default: val = 8'($urandom_range(255));
        endcase
        return val;
    endfunction

    function automatic t_pixel_row make_row(input logic [1:0] src, input logic [1:0] depth,
                                            input logic [7:0] luma, input logic [7:0] cb,
                                            input logic [7:0] cr, input logic [23:0] word,
                                            input bit known, input logic [23:0] want);
        t_pixel_row row;
        row.src   = src;
        row.depth = depth;
        row.luma  = luma;
        row.cb    = cb;
        row.cr    = cr;
        row.word  = word;
        row.known = known;
        row.want  = want;
        return row;
    endfunction

    // Result checker: every strobe must match the oldest pending pixel.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected result pixel %06h", o_pixel));
            end else if (o_pixel !== pending_pixels[0]) begin
                report_mismatch($sformatf("pixel %06h, expected %06h", o_pixel,
                                          pending_pixels[0]));
                void'(pending_pixels.pop_front());
            end else begin
                void'(pending_pixels.pop_front());
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("video_pixel_format_converter_top test failed");
            $finish;
        end
    end

    // Stimulus.
    initial begin
        logic [1:0] src;
        logic [1:0] depth;

        // Directed rows: extremes, clamps, ignored fields, truncation, unknown source.
        pixel_table.push_back(make_row(SRC_PLANAR_420, DEPTH_RGB565, 8'hFF, 8'h80, 8'h80,
                                       24'h000000, 1, 24'h00FFFF));
        pixel_table.push_back(make_row(SRC_PLANAR_420, DEPTH_RGB565, 8'h00, 8'h80, 8'h80,
                                       24'hFFFFFF, 1, 24'h000000));
        pixel_table.push_back(make_row(SRC_PLANAR_420, DEPTH_RGB565, 8'h10, 8'h80, 8'h80,
                                       24'h000000, 1, 24'h000000));
        pixel_table.push_back(make_row(SRC_PLANAR_420, DEPTH_RGB565, 8'h80, 8'h00, 8'hFF,
                                       24'h000000, 0, 24'h0));
        pixel_table.push_back(make_row(SRC_PLANAR_420, DEPTH_RGB565, 8'h80, 8'hFF, 8'h00,
                                       24'h000000, 0, 24'h0));
        pixel_table.push_back(make_row(SRC_PLANAR_420, DEPTH_RGB555, 8'hFF, 8'h80, 8'h80,
                                       24'h000000, 1, 24'h007FFF));
        pixel_table.push_back(make_row(SRC_PLANAR_420, DEPTH_RGB555, 8'hEB, 8'hFF, 8'hFF,
                                       24'h000000, 0, 24'h0));
        pixel_table.push_back(make_row(SRC_PLANAR_420, DEPTH_BGR24, 8'hFF, 8'h80, 8'h80,
                                       24'h000000, 1, 24'hFFFFFF));
        pixel_table.push_back(make_row(SRC_PLANAR_420, DEPTH_BGR24, 8'h10, 8'h80, 8'h80,
                                       24'hFFFFFF, 1, 24'h000000));
        pixel_table.push_back(make_row(SRC_PLANAR_420, DEPTH_BGR32, 8'h00, 8'h00, 8'h00,
                                       24'h000000, 0, 24'h0));
        pixel_table.push_back(make_row(SRC_PACKED_422, DEPTH_BGR24, 8'hFF, 8'h80, 8'h80,
                                       24'h000000, 1, 24'hFFFFFF));
        pixel_table.push_back(make_row(SRC_PACKED_422, DEPTH_BGR24, 8'h00, 8'h80, 8'h80,
                                       24'hFFFFFF, 1, 24'h000000));
        pixel_table.push_back(make_row(SRC_PACKED_422, DEPTH_BGR24, 8'h00, 8'hFF, 8'hFF,
                                       24'h000000, 0, 24'h0));
        pixel_table.push_back(make_row(SRC_PACKED_422, DEPTH_RGB565, 8'hFF, 8'h00, 8'h00,
                                       24'h000000, 0, 24'h0));
        pixel_table.push_back(make_row(SRC_PACKED_422, DEPTH_RGB555, 8'h01, 8'h81, 8'h7F,
                                       24'h000000, 0, 24'h0));
        pixel_table.push_back(make_row(SRC_RGB32, DEPTH_BGR24, 8'h00, 8'h00, 8'h00,
                                       24'h123456, 1, 24'h123456));
        pixel_table.push_back(make_row(SRC_RGB32, DEPTH_BGR32, 8'h00, 8'h00, 8'h00,
                                       24'hFFFFFF, 1, 24'hFFFFFF));
        pixel_table.push_back(make_row(SRC_RGB32, DEPTH_BGR32, 8'hFF, 8'hFF, 8'hFF,
                                       24'h000000, 1, 24'h000000));
        pixel_table.push_back(make_row(SRC_RGB32, DEPTH_RGB565, 8'h00, 8'h00, 8'h00,
                                       24'hFFFFFF, 1, 24'h00FFFF));
        pixel_table.push_back(make_row(SRC_RGB32, DEPTH_RGB555, 8'h00, 8'h00, 8'h00,
                                       24'h07070F, 0, 24'h0));
        pixel_table.push_back(make_row(SRC_RGB32, DEPTH_RGB565, 8'hFF, 8'hFF, 8'hFF,
                                       24'h0C0C0C, 0, 24'h0));
        pixel_table.push_back(make_row(SRC_UNKNOWN, DEPTH_BGR24, 8'hFF, 8'h00, 8'hFF,
                                       24'hFFFFFF, 1, 24'h000000));
        pixel_table.push_back(make_row(SRC_UNKNOWN, DEPTH_RGB555, 8'h00, 8'hFF, 8'h00,
                                       24'hABCDEF, 1, 24'h000000));

        // Reset.
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part; the configuration changes only between drained groups.
        foreach (pixel_table[i]) begin
            if (pixel_table[i].src != src_fmt || pixel_table[i].depth != out_depth) begin
                drain_pipeline();
                apply_config(pixel_table[i].src, pixel_table[i].depth);
            end
            push_pixel(pixel_table[i].luma, pixel_table[i].cb, pixel_table[i].cr,
                       pixel_table[i].word, pixel_table[i].known, pixel_table[i].want);
        end

        // Random part: each known source at every depth, then the unknown source at RGB555.
        for (int phase = 0; phase < 13; phase++) begin
            src   = 2'(phase / 4);
            depth = 2'(phase % 4);
            drain_pipeline();
            apply_config(src, depth);
            // One phase runs back to back with no gaps at all.
            gaps_on = (phase != 5);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                push_pixel(rand_byte(), rand_byte(), rand_byte(),
                           {rand_byte(), rand_byte(), rand_byte()}, 0, 24'h0);
            end
        end

        // Wind down.
        start <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("video_pixel_format_converter_top test passed");
        end else begin
            $display("video_pixel_format_converter_top test failed");
        end
        $finish;
    end

endmodule
